// File: rtl/sdcsd_pkg.sv
`default_nettype none

package sdcsd_pkg;

    // CSD_STRUCTURE codes
    localparam logic [1:0] CSD_VER_1_0      = 2'd0;
    localparam logic [1:0] CSD_VER_2_0      = 2'd1;
    localparam logic [1:0] CSD_VER_3_0      = 2'd2;
    localparam logic [1:0] CSD_VER_RESERVED = 2'd3;

    // Block size the capacity is counted in, as log2 of bytes
    localparam int unsigned BLOCK_BYTES_LOG2 = 9;

    // The NSAC field is multiplied by 100 to give access_clocks
    localparam logic [14:0] NSAC_SCALE = 15'd100;

    // Decoded view of one CSD image
    typedef struct packed {
        logic [1:0]  structure_version;
        logic        high_capacity;
        logic [38:0] block_count;
        logic [36:0] speed_bps;
        logic [14:0] access_clocks;
        logic [29:0] access_time;
        logic [2:0]  write_speed_factor;
    } sdcsd_info_t;

    // Time value / transfer rate mantissa, scaled by ten
    function automatic logic [6:0] mant_x10(input logic [3:0] code);
        logic [6:0] m;
        case (code)
            4'd0:    m = 7'd0;
            4'd1:    m = 7'd10;
            4'd2:    m = 7'd12;
            4'd3:    m = 7'd13;
            4'd4:    m = 7'd15;
            4'd5:    m = 7'd20;
            4'd6:    m = 7'd25;
            4'd7:    m = 7'd30;
            4'd8:    m = 7'd35;
            4'd9:    m = 7'd40;
            4'd10:   m = 7'd45;
            4'd11:   m = 7'd50;
            4'd12:   m = 7'd55;
            4'd13:   m = 7'd60;
            4'd14:   m = 7'd70;
            4'd15:   m = 7'd80;
            default: m = 7'd0;
        endcase
        return m;
    endfunction

    // Transfer rate unit: 100 kbit/s steps, with the mantissa's x10 folded in
    function automatic logic [36:0] speed_scale(input logic [2:0] unit);
        logic [36:0] s;
        case (unit)
            3'd0:    s = 37'd10000;
            3'd1:    s = 37'd100000;
            3'd2:    s = 37'd1000000;
            3'd3:    s = 37'd10000000;
            3'd4:    s = 37'd100000000;
            3'd5:    s = 37'd1000000000;
            default: s = 37'd0;
        endcase
        return s;
    endfunction

    // Access time unit, in tenths of ns with the mantissa's x10 folded in
    function automatic logic [29:0] taac_scale(input logic [2:0] unit);
        logic [29:0] s;
        case (unit)
            3'd0:    s = 30'd1;
            3'd1:    s = 30'd10;
            3'd2:    s = 30'd100;
            3'd3:    s = 30'd1000;
            3'd4:    s = 30'd10000;
            3'd5:    s = 30'd100000;
            3'd6:    s = 30'd1000000;
            3'd7:    s = 30'd10000000;
            default: s = 30'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sdcsd_if.sv
`default_nettype none

// Channel carrying one raw CSD image
interface sdcsd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] csd_upper;
    logic [63:0] csd_lower;

    modport source (output valid, output csd_upper, output csd_lower, input ready);
    modport sink   (input valid, input csd_upper, input csd_lower, output ready);
endinterface

// Channel carrying one decoded CSD word
interface sdcsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  structure_version;
    logic        high_capacity;
    logic [38:0] block_count;
    logic [36:0] speed_bps;
    logic [14:0] access_clocks;
    logic [29:0] access_time;
    logic [2:0]  write_speed_factor;

    modport source (
        output valid, output structure_version, output high_capacity,
        output block_count, output speed_bps, output access_clocks,
        output access_time, output write_speed_factor, input ready
    );
    modport sink (
        input valid, input structure_version, input high_capacity,
        input block_count, input speed_bps, input access_clocks,
        input access_time, input write_speed_factor, output ready
    );
endinterface

`default_nettype wire

// File: rtl/sdcsd_decode.sv
`default_nettype none

module sdcsd_decode
    import sdcsd_pkg::*;
(
    input  wire logic [63:0] csd_upper,
    input  wire logic [63:0] csd_lower,
    output sdcsd_info_t      info
);

    logic [127:0] csd;
    logic [1:0]   ver;
    logic [12:0]  v1_size;
    logic [2:0]   v1_mult;
    logic [3:0]   v1_bl_len;
    logic [4:0]   v1_shift_sum;
    logic [3:0]   v1_shift;
    logic [38:0]  blocks_v1;
    logic [38:0]  blocks_v2;
    logic [38:0]  blocks_v3;

    always_comb
    begin
        csd = {csd_upper, csd_lower};
        ver = csd[127:126];

        // Version 1.0: (C_SIZE+1) * 2^(C_SIZE_MULT+2) * 2^(READ_BL_LEN-9)
        v1_size      = {1'b0, csd[73:62]} + 13'd1;
        v1_mult      = csd[49:47];
        v1_bl_len    = csd[83:80];
        v1_shift_sum = {2'b00, v1_mult} + {1'b0, v1_bl_len} + 5'd2 - 5'(BLOCK_BYTES_LOG2);
        v1_shift     = v1_shift_sum[3:0];
        if (v1_bl_len < 4'(BLOCK_BYTES_LOG2))
        begin
            blocks_v1 = '0;
        end
        else
        begin
            blocks_v1 = 39'(v1_size) << v1_shift;
        end

        // Versions 2.0 and 3.0: (C_SIZE+1) * 1024
        blocks_v2 = {6'd0, ({1'b0, csd[69:48]} + 23'd1), 10'd0};
        blocks_v3 = {({1'b0, csd[75:48]} + 29'd1), 10'd0};

        info.structure_version = ver;
        info.high_capacity     = (ver != CSD_VER_1_0);
        case (ver)
            CSD_VER_1_0: info.block_count = blocks_v1;
            CSD_VER_2_0: info.block_count = blocks_v2;
            CSD_VER_3_0: info.block_count = blocks_v3;
            default:     info.block_count = '0;
        endcase

        // Scale the table mantissas; reserved codes fall out as zero
        info.speed_bps     = 37'(mant_x10(csd[102:99])) * speed_scale(csd[98:96]);
        info.access_time   = 30'(mant_x10(csd[118:115])) * taac_scale(csd[114:112]);
        info.access_clocks = 15'(csd[111:104]) * NSAC_SCALE;

        info.write_speed_factor = csd[28:26];
    end

endmodule

`default_nettype wire

// File: rtl/sd_csd_register_decoder.sv
// Path: an accepted CSD word lands in an input register, and its decoded word
// in a result register that drives rsp. Throughput: one word per cycle while
// rsp is ready; they hold the two stages, and the decode is a single pass.
// Reset: rst_n clears both stage valid flags at once; no word is in flight
// after reset, and payload registers are left as they are.
`default_nettype none

module sd_csd_register_decoder
    import sdcsd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sdcsd_in_if.sink    req,
    sdcsd_out_if.source rsp
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [63:0] in_upper_reg;
    logic [63:0] in_lower_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    sdcsd_info_t out_info_reg;
    sdcsd_info_t decoded;
    logic        in_take;
    logic        advance;

    // Move a word on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take = req.valid && req.ready;

    sdcsd_decode u_decode (
        .csd_upper (in_upper_reg),
        .csd_lower (in_lower_reg),
        .info      (decoded)
    );

    // Next valid flags for both stages
    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture incoming word and decoded result
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_upper_reg <= req.csd_upper;
            in_lower_reg <= req.csd_lower;
        end
        if (advance)
        begin
            out_info_reg <= decoded;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.structure_version  = out_info_reg.structure_version;
    assign rsp.high_capacity      = out_info_reg.high_capacity;
    assign rsp.block_count        = out_info_reg.block_count;
    assign rsp.speed_bps          = out_info_reg.speed_bps;
    assign rsp.access_clocks      = out_info_reg.access_clocks;
    assign rsp.access_time        = out_info_reg.access_time;
    assign rsp.write_speed_factor = out_info_reg.write_speed_factor;

    // An accepted word sits in the input stage on the next cycle
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg)
        else $error("accepted word missing from input stage");

    // A word leaving the input stage shows up at the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word missing from result register");

    // Never refuse a word while both stages are empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid_reg && !out_valid_reg) |-> req.ready)
        else $error("input refused with empty pipeline");

    // Flag tracks the version field
    a_hc_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_info_reg.high_capacity ==
                           (out_info_reg.structure_version != CSD_VER_1_0)))
        else $error("high capacity flag disagrees with version");

    // Reserved version reports no capacity
    a_reserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_info_reg.structure_version == CSD_VER_RESERVED)
            |-> (out_info_reg.block_count == '0))
        else $error("reserved version with nonzero block count");

endmodule

`default_nettype wire

// File: test/sdcsd_scoreboard_pkg.sv
`default_nettype none

package sdcsd_scoreboard_pkg;

    import sdcsd_pkg::*;

    // Predicts the decoded word for each accepted CSD image and checks results in order
    class csd_decode_scoreboard;
        sdcsd_info_t pending_info[$];
        int unsigned words_noted;
        int unsigned words_checked;
        int unsigned mismatches;
        logic [6:0]  mant_tab [16];

        function new();
            mant_tab = '{7'd0, 7'd10, 7'd12, 7'd13, 7'd15, 7'd20, 7'd25, 7'd30,
                         7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd70, 7'd80};
            words_noted   = 0;
            words_checked = 0;
            mismatches    = 0;
        endfunction

        function longint unsigned pow10(int unsigned n);
            longint unsigned p;
            p = 1;
            repeat (n) p = p * 10;
            return p;
        endfunction

        // Decode one CSD image; vector bit b is CSD bit b
        function sdcsd_info_t decode_csd(logic [127:0] csd);
            sdcsd_info_t     w;
            longint unsigned c_size;
            longint unsigned mult;
            longint unsigned bl_len;
            longint unsigned blocks;
            longint unsigned speed;
            longint unsigned taac;
            longint unsigned nsac;
            c_size = 0;
            blocks = 0;
            w.structure_version = csd[127:126];
            w.high_capacity     = (csd[127:126] != CSD_VER_1_0);
            case (csd[127:126])
                CSD_VER_1_0:
                begin
                    // Small read block lengths floor to zero blocks
                    c_size = 64'(csd[73:62]);
                    mult   = 64'(csd[49:47]);
                    bl_len = 64'(csd[83:80]);
                    blocks = (c_size + 1) * (64'd4 << mult)
                             * ((64'd1 << bl_len) >> BLOCK_BYTES_LOG2);
                end
                CSD_VER_2_0:
                begin
                    c_size = 64'(csd[69:48]);
                    blocks = (c_size + 1) << 10;
                end
                CSD_VER_3_0:
                begin
                    c_size = 64'(csd[75:48]);
                    blocks = (c_size + 1) << 10;
                end
                default:
                begin
                    // Reserved structure gives no capacity
                    blocks = 0;
                end
            endcase
            w.block_count = blocks[38:0];

            // Unit codes past 5 run off the rate table
            if (csd[98:96] <= 3'd5)
                speed = longint'(mant_tab[csd[102:99]]) * pow10(int'(csd[98:96]) + 4);
            else
                speed = 0;
            w.speed_bps = speed[36:0];

            nsac = 64'(csd[111:104]);
            nsac = nsac * 64'(NSAC_SCALE);
            w.access_clocks = nsac[14:0];

            taac = longint'(mant_tab[csd[118:115]]) * pow10(int'(csd[114:112]));
            w.access_time = taac[29:0];

            w.write_speed_factor = csd[28:26];
            return w;
        endfunction

        function void note_csd(logic [63:0] upper, logic [63:0] lower);
            pending_info.push_back(decode_csd({upper, lower}));
            words_noted++;
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v != act_v)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch word %0d %s: expected %0d actual %0d",
                             words_checked, name, exp_v, act_v);
            end
        endfunction

        // Compare one result word against the oldest prediction
        function void check_info(sdcsd_info_t act);
            sdcsd_info_t exp_w;
            if (pending_info.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: expected none actual %h", act);
                return;
            end
            exp_w = pending_info.pop_front();
            compare_field("structure_version", 64'(exp_w.structure_version),
                          64'(act.structure_version));
            compare_field("high_capacity", 64'(exp_w.high_capacity),
                          64'(act.high_capacity));
            compare_field("block_count", 64'(exp_w.block_count), 64'(act.block_count));
            compare_field("speed_bps", 64'(exp_w.speed_bps), 64'(act.speed_bps));
            compare_field("access_clocks", 64'(exp_w.access_clocks),
                          64'(act.access_clocks));
            compare_field("access_time", 64'(exp_w.access_time), 64'(act.access_time));
            compare_field("write_speed_factor", 64'(exp_w.write_speed_factor),
                          64'(act.write_speed_factor));
            words_checked++;
        endfunction

        function int unsigned pending();
            return pending_info.size();
        endfunction
    endclass

endpackage

`default_nettype wire

// File: test/sd_csd_register_decoder_test.sv
`default_nettype none

module sd_csd_register_decoder_test;

    import sdcsd_pkg::*;
    import sdcsd_scoreboard_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1150;
    localparam int unsigned QUIET_FIRST  = 600;
    localparam int unsigned QUIET_LAST   = 700;
    localparam int unsigned HOLD_AFTER   = 300;
    localparam int unsigned HOLD_CYCLES  = 64;

    logic clk;
    logic rst_n;
    logic hold_rsp;
    int unsigned sent_words;

    csd_decode_scoreboard csd_board;

    sdcsd_in_if  req_if ();
    sdcsd_out_if rsp_if ();

    sd_csd_register_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Offer one CSD word after a random gap, none in the quiet window, and hold it until accepted
    task automatic send_csd(input logic [127:0] image);
        int unsigned gap;
        if (sent_words >= QUIET_FIRST && sent_words < QUIET_LAST)
            gap = 0;
        else
            gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.csd_upper <= image[127:64];
        req_if.csd_lower <= image[63:0];
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        csd_board.note_csd(image[127:64], image[63:0]);
        sent_words++;
    endtask

    // Result side: check each accepted word, then stall at random
    initial
    begin : rsp_side
        int unsigned stall_left;
        int unsigned got_words;
        sdcsd_info_t got;
        stall_left   = 0;
        got_words    = 0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.structure_version  = rsp_if.structure_version;
                got.high_capacity      = rsp_if.high_capacity;
                got.block_count        = rsp_if.block_count;
                got.speed_bps          = rsp_if.speed_bps;
                got.access_clocks      = rsp_if.access_clocks;
                got.access_time        = rsp_if.access_time;
                got.write_speed_factor = rsp_if.write_speed_factor;
                csd_board.check_info(got);
                got_words++;
                if (got_words >= QUIET_FIRST && got_words < QUIET_LAST)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 5);
            end
            else if (stall_left != 0)
                stall_left--;
            rsp_if.ready <= (stall_left == 0) && !hold_rsp;
        end
    end

    // Hold off the result side for a long stretch so the input backs up
    initial
    begin
        hold_rsp <= 1'b0;
        wait (sent_words >= HOLD_AFTER);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Reset, directed words, random words, drain
    initial
    begin : stimulus
        logic [127:0] image;
        logic [127:0] directed[$];
        int unsigned  k;
        csd_board  = new();
        sent_words = 0;
        rst_n            = 1'b0;
        req_if.valid     <= 1'b0;
        req_if.csd_upper <= '0;
        req_if.csd_lower <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes
        directed.push_back('0);
        directed.push_back('1);
        // Version 1.0 at full size
        image = '0;
        image[127:126] = CSD_VER_1_0;
        image[73:62]   = '1;
        image[49:47]   = '1;
        image[83:80]   = 4'd15;
        directed.push_back(image);
        // Version 1.0 at the smallest block length that gives a nonzero block count
        image = '0;
        image[83:80] = 4'd9;
        directed.push_back(image);
        // Version 1.0 with a block length below the 512-byte block
        image = '1;
        image[127:126] = CSD_VER_1_0;
        image[83:80]   = 4'd8;
        directed.push_back(image);
        // Version 2.0 at both ends of C_SIZE
        image = '0;
        image[127:126] = CSD_VER_2_0;
        image[69:48]   = '1;
        directed.push_back(image);
        image = '1;
        image[127:126] = CSD_VER_2_0;
        image[69:48]   = '0;
        directed.push_back(image);
        // Version 3.0 at both ends of C_SIZE
        image = '0;
        image[127:126] = CSD_VER_3_0;
        image[75:48]   = '1;
        directed.push_back(image);
        image = {$urandom, $urandom, $urandom, $urandom};
        image[127:126] = CSD_VER_3_0;
        image[75:48]   = '0;
        directed.push_back(image);
        // Reserved structure version
        image = {$urandom, $urandom, $urandom, $urandom};
        image[127:126] = CSD_VER_RESERVED;
        directed.push_back(image);
        // Every rate and access time unit, reserved rate units included
        for (k = 0; k < 8; k++)
        begin
            image = {$urandom, $urandom, $urandom, $urandom};
            image[98:96]   = k[2:0];
            image[102:99]  = 4'd15 - k[3:0];
            image[114:112] = k[2:0];
            image[118:115] = 4'd15 - k[3:0];
            directed.push_back(image);
        end
        // Reserved mantissa code on both tables
        image = '1;
        image[127:126] = CSD_VER_3_0;
        image[98:96]   = 3'd5;
        image[102:99]  = 4'd0;
        image[118:115] = 4'd0;
        directed.push_back(image);
        // Largest rate and access time, full NSAC and R2W
        image = '0;
        image[98:96]   = 3'd5;
        image[102:99]  = 4'd15;
        image[114:112] = 3'd7;
        image[118:115] = 4'd15;
        image[111:104] = '1;
        image[28:26]   = '1;
        directed.push_back(image);

        foreach (directed[i])
            send_csd(directed[i]);

        // Random images, mostly with a usable read block length
        repeat (RANDOM_WORDS)
        begin
            image = {$urandom, $urandom, $urandom, $urandom};
            if ($urandom_range(0, 3) != 0)
                image[83:80] = 4'($urandom_range(9, 15));
            send_csd(image);
        end
        req_if.valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray word
        while (csd_board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d CSD words (%0d directed), %0d decoded words checked",
                 csd_board.words_noted, directed.size(), csd_board.words_checked);
        $display("mismatches %0d, words still pending %0d",
                 csd_board.mismatches, csd_board.pending());
        if (csd_board.mismatches == 0 && csd_board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
